// ----- src/pdb_pkg.sv -----
// pdb_pkg: shared types, blend mode codes and per-channel arithmetic
`timescale 1ns / 1ps

package pdb_pkg;

    typedef logic [7:0]  t_chan;
    typedef logic [31:0] t_pixel;
    typedef logic [3:0]  t_mode;
    typedef logic [8:0]  t_scale;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned NUM_CH = 4;

    localparam t_chan  CHAN_MAX  = 8'hFF;
    localparam t_scale SCALE_ONE = 9'd256;

    // blend mode codes
    localparam t_mode MODE_CLEAR    = 4'd0;
    localparam t_mode MODE_SRC      = 4'd1;
    localparam t_mode MODE_DST      = 4'd2;
    localparam t_mode MODE_SRCOVER  = 4'd3;
    localparam t_mode MODE_DSTOVER  = 4'd4;
    localparam t_mode MODE_SRCIN    = 4'd5;
    localparam t_mode MODE_DSTIN    = 4'd6;
    localparam t_mode MODE_SRCOUT   = 4'd7;
    localparam t_mode MODE_DSTOUT   = 4'd8;
    localparam t_mode MODE_SRCATOP  = 4'd9;
    localparam t_mode MODE_DSTATOP  = 4'd10;
    localparam t_mode MODE_XOR      = 4'd11;
    localparam t_mode MODE_PLUS     = 4'd12;
    localparam t_mode MODE_MODULATE = 4'd13;

    // floor(c * s / 256) on every channel of a pixel, s in 0..256
    function automatic t_pixel scale_px(t_pixel px, t_scale s);
        logic [16:0] prod;
        t_pixel      res;
        res = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            prod = {9'd0, px[k*CHAN_W +: CHAN_W]} * {8'd0, s};
            res[k*CHAN_W +: CHAN_W] = prod[15:8];
        end
        return res;
    endfunction

    // rounded a * b / 255
    function automatic t_chan mul255(t_chan a, t_chan b);
        logic [16:0] p;
        logic [16:0] q;
        p = ({9'd0, a} * {9'd0, b}) + 17'd128;
        q = p + {8'd0, p[16:8]};
        return q[15:8];
    endfunction

    // add two channels, clamp at full scale
    function automatic t_chan sat_add(t_chan x, t_chan y);
        logic [8:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[8] ? CHAN_MAX : s[7:0];
    endfunction

    // color = sat(m(fs, s) + m(fd, d)) on r, g, b; alpha passed in
    function automatic t_pixel mix_px(t_pixel src, t_pixel dst, t_chan fs, t_chan fd,
                                      t_chan alpha);
        t_pixel res;
        res = '0;
        for (int k = 1; k < NUM_CH; k++) begin
            res[k*CHAN_W +: CHAN_W] = sat_add(mul255(fs, src[k*CHAN_W +: CHAN_W]),
                                              mul255(fd, dst[k*CHAN_W +: CHAN_W]));
        end
        res[CHAN_W-1:0] = alpha;
        return res;
    endfunction

endpackage

// ----- src/pdb_if.sv -----
// pdb_if: valid/ready channel interfaces for pixel requests and blended results
`timescale 1ns / 1ps

interface pdb_in_if;
    logic           valid;
    logic           ready;
    pdb_pkg::t_mode  cmd;
    pdb_pkg::t_pixel src_pixel;
    pdb_pkg::t_pixel dst_pixel;

    modport source (output valid, output cmd, output src_pixel, output dst_pixel,
                    input ready);
    modport sink   (input valid, input cmd, input src_pixel, input dst_pixel,
                    output ready);
endinterface

interface pdb_out_if;
    logic            valid;
    logic            ready;
    pdb_pkg::t_pixel blended_pixel;

    modport source (output valid, output blended_pixel, input ready);
    modport sink   (input valid, input blended_pixel, output ready);
endinterface

// ----- src/porter_duff_pixel_blend.sv -----
// porter_duff_pixel_blend: two-stage porter-duff compositor for rgba8888 pixels
//
// i_req carries one word per pixel: blend mode, source and destination
// pixel (premultiplied, red in bits 31:24, alpha in 7:0). o_rsp returns
// one blended pixel word for every request word, in order.
// Both channels use valid/ready; a word moves when both are high.
// A request word passes an input register, the blend logic, then the
// result register before it shows on o_rsp. Throughput is one pixel
// per cycle while o_rsp.ready stays high; each stage takes a new word
// when it is empty or when the word it holds moves on in the same cycle.
// When the receiver stalls, the result register holds its word and the
// input register fills behind it; i_req.ready drops only when both hold
// a word and o_rsp.ready is low, so up to two words wait inside.
// Synchronous reset (i_rst_n low) empties both stages; no word is lost
// or shown after reset, and the block is ready in the first cycle after.
`timescale 1ns / 1ps

module porter_duff_pixel_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdb_in_if.sink      i_req,
    pdb_out_if.source   o_rsp
);

    logic            r_v1;
    logic            n_v1;
    pdb_pkg::t_mode  r_cmd;
    pdb_pkg::t_pixel r_src;
    pdb_pkg::t_pixel r_dst;
    logic            r_v2;
    logic            n_v2;
    pdb_pkg::t_pixel r_pix;
    pdb_pkg::t_pixel n_pix;
    logic            s2_free;
    logic            s1_free;
    logic            in_acc;
    logic            s1_move;

    // stage handshake
    assign s2_free = !r_v2 || o_rsp.ready;
    assign s1_move = r_v1 && s2_free;
    assign s1_free = !r_v1 || s2_free;
    assign in_acc  = i_req.valid && s1_free;

    assign i_req.ready = s1_free;

    assign n_v1 = in_acc || (r_v1 && !s2_free);
    assign n_v2 = s1_move || (r_v2 && !o_rsp.ready);

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_req.cmd;
            r_src <= i_req.src_pixel;
            r_dst <= i_req.dst_pixel;
        end
    end

    // blend logic
    pdb_blend_core u_core (
        .i_cmd   (r_cmd),
        .i_src   (r_src),
        .i_dst   (r_dst),
        .o_pixel (n_pix)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_pix <= n_pix;
        end
    end

    assign o_rsp.valid         = r_v2;
    assign o_rsp.blended_pixel = r_pix;

endmodule

// ----- src/pdb_blend_core.sv -----
// pdb_blend_core: combinational porter-duff compositing of one pixel pair
`timescale 1ns / 1ps

module pdb_blend_core (
    input  pdb_pkg::t_mode  i_cmd,
    input  pdb_pkg::t_pixel i_src,
    input  pdb_pkg::t_pixel i_dst,
    output pdb_pkg::t_pixel o_pixel
);

    pdb_pkg::t_chan  sa;
    pdb_pkg::t_chan  da;
    pdb_pkg::t_chan  inv_sa8;
    pdb_pkg::t_chan  inv_da8;
    pdb_pkg::t_scale inv_sa;
    pdb_pkg::t_scale inv_da;
    pdb_pkg::t_scale sa_p1;
    pdb_pkg::t_scale da_p1;
    logic [8:0]      xa_sum;
    logic [8:0]      xa_prod2;
    logic [8:0]      xa_diff;
    pdb_pkg::t_chan  xor_alpha;
    pdb_pkg::t_pixel plus_px;
    pdb_pkg::t_pixel mod_px;

    // alphas and their scale factors
    assign sa      = i_src[7:0];
    assign da      = i_dst[7:0];
    assign inv_sa8 = pdb_pkg::CHAN_MAX - sa;
    assign inv_da8 = pdb_pkg::CHAN_MAX - da;
    assign inv_sa  = pdb_pkg::SCALE_ONE - {1'b0, sa};
    assign inv_da  = pdb_pkg::SCALE_ONE - {1'b0, da};
    assign sa_p1   = {1'b0, sa} + 9'd1;
    assign da_p1   = {1'b0, da} + 9'd1;

    // xor alpha: sa + da - 2 m(sa, da), clamped to 0..255
    assign xa_sum   = {1'b0, sa} + {1'b0, da};
    assign xa_prod2 = {pdb_pkg::mul255(sa, da), 1'b0};
    assign xa_diff  = xa_sum - xa_prod2;
    always_comb begin
        if (xa_sum < xa_prod2) begin
            xor_alpha = '0;
        end else if (xa_diff[8]) begin
            xor_alpha = pdb_pkg::CHAN_MAX;
        end else begin
            xor_alpha = xa_diff[7:0];
        end
    end

    // plus and modulate work channel by channel, alpha included
    always_comb begin
        plus_px = '0;
        mod_px  = '0;
        for (int k = 0; k < pdb_pkg::NUM_CH; k++) begin
            plus_px[k*pdb_pkg::CHAN_W +: pdb_pkg::CHAN_W] =
                pdb_pkg::sat_add(i_src[k*pdb_pkg::CHAN_W +: pdb_pkg::CHAN_W],
                                 i_dst[k*pdb_pkg::CHAN_W +: pdb_pkg::CHAN_W]);
            mod_px[k*pdb_pkg::CHAN_W +: pdb_pkg::CHAN_W] =
                pdb_pkg::mul255(i_src[k*pdb_pkg::CHAN_W +: pdb_pkg::CHAN_W],
                                i_dst[k*pdb_pkg::CHAN_W +: pdb_pkg::CHAN_W]);
        end
    end

    // mode select; over modes add whole words and wrap
    always_comb begin
        case (i_cmd)
            pdb_pkg::MODE_CLEAR:    o_pixel = '0;
            pdb_pkg::MODE_SRC:      o_pixel = i_src;
            pdb_pkg::MODE_DST:      o_pixel = i_dst;
            pdb_pkg::MODE_SRCOVER:  o_pixel = i_src + pdb_pkg::scale_px(i_dst, inv_sa);
            pdb_pkg::MODE_DSTOVER:  o_pixel = i_dst + pdb_pkg::scale_px(i_src, inv_da);
            pdb_pkg::MODE_SRCIN:    o_pixel = pdb_pkg::scale_px(i_src, da_p1);
            pdb_pkg::MODE_DSTIN:    o_pixel = pdb_pkg::scale_px(i_dst, sa_p1);
            pdb_pkg::MODE_SRCOUT:   o_pixel = pdb_pkg::scale_px(i_src, inv_da);
            pdb_pkg::MODE_DSTOUT:   o_pixel = pdb_pkg::scale_px(i_dst, inv_sa);
            pdb_pkg::MODE_SRCATOP:  o_pixel = pdb_pkg::mix_px(i_src, i_dst, da, inv_sa8, da);
            pdb_pkg::MODE_DSTATOP:  o_pixel = pdb_pkg::mix_px(i_src, i_dst, inv_da8, sa, sa);
            pdb_pkg::MODE_XOR:      o_pixel = pdb_pkg::mix_px(i_src, i_dst, inv_da8, inv_sa8,
                                                              xor_alpha);
            pdb_pkg::MODE_PLUS:     o_pixel = plus_px;
            pdb_pkg::MODE_MODULATE: o_pixel = mod_px;
            default:                o_pixel = '0;
        endcase
    end

endmodule

// ----- src/pdb_checker.sv -----
// pdb_checker: port-level checks of the compositor, bound to the top level
`timescale 1ns / 1ps

module pdb_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            i_req_ready,
    input pdb_pkg::t_mode  i_req_cmd,
    input pdb_pkg::t_pixel i_req_src,
    input logic            i_rsp_valid,
    input logic            i_rsp_ready,
    input pdb_pkg::t_pixel i_rsp_pixel
);

    logic in_acc;
    assign in_acc = i_req_valid && i_req_ready;

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result word shown right after reset");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result word dropped while stalled");

    // a clear request followed by a free output shows up as a zero word
    a_clear_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_cmd == pdb_pkg::MODE_CLEAR) ##1 i_rsp_ready
            |=> (i_rsp_valid && i_rsp_pixel == '0))
        else $error("clear word missing or nonzero after two cycles");

    // src mode passes the source word through in order
    a_src_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_cmd == pdb_pkg::MODE_SRC) ##1 i_rsp_ready
            |=> (i_rsp_valid && i_rsp_pixel == $past(i_req_src, 2)))
        else $error("src word not passed through after two cycles");

endmodule

bind porter_duff_pixel_blend pdb_checker u_pdb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_cmd   (i_req.cmd),
    .i_req_src   (i_req.src_pixel),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_pixel (o_rsp.blended_pixel)
);
